/* design/rtpst_pkg.sv */
// Package for the RTP sequence tracker: field widths, verdict codes and
// the payload structs of the header and result channels. No dependencies.
`timescale 1ns / 1ps

package rtpst_pkg;

  localparam int unsigned SrcW   = 32;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CntW   = 16;
  localparam int unsigned TotalW = 32;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT    = 2'd0,
    VERDICT_DUPLICATE = 2'd1,
    VERDICT_OLD_TIME  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [SrcW-1:0]  source_id;
    logic [SeqW-1:0]  seq_number;
    logic [TimeW-1:0] media_time;
    logic [CntW-1:0]  sample_count;
  } hdr_t;

  typedef struct packed {
    verdict_t                verdict;
    logic signed [TimeW-1:0] time_jump;
    logic [TotalW-1:0]       packet_total;
    logic [TotalW-1:0]       duplicate_total;
    logic [TotalW-1:0]       lost_total;
  } result_t;

endpackage

/* design/rtpst_chan_if.sv */
// Valid/ready channel interface used for both the header and result streams.
// The payload type is a parameter; the structs come from rtpst_pkg.
`timescale 1ns / 1ps

interface rtpst_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/rtp_sequence_tracker_top.sv */
// Top level of the RTP sequence tracker: input register, single-pass check
// logic and result register. Uses rtpst_pkg and rtpst_chan_if.
`timescale 1ns / 1ps

// Usage
// The in_ch channel carries one parsed RTP header per transaction: source
// id, sequence number, timestamp and sample count. The out_ch channel gives
// exactly one result transaction per header: a verdict (accept, duplicate or
// old timestamp), the signed timestamp step against the expected one (all
// ones on a duplicate), and the packet, duplicate and lost counters after it.
// A header is first captured in an input register. In the next stage the
// sequence and timestamp checks and all counter updates are done in one pass
// and written into the result register, together with the tracking state.
// Throughput is one header per cycle while the receiver does not stall;
// the only loop is the tracking state, which is read and updated in that
// same single stage.
// When the receiver stalls, the result register holds; a header waiting in
// the input register stays there, and in_ch.ready drops only once both
// registers are full. A new header is accepted whenever the input register
// is empty or moves on in the same cycle.
// Reset (rst_n low, synchronous) empties both registers and clears tracking,
// so the first header afterwards restarts tracking whatever its source id.

module rtp_sequence_tracker_top (
  input  logic         clk,
  input  logic         rst_n,
  rtpst_chan_if.sink   in_ch,
  rtpst_chan_if.source out_ch
);

  // Input register stage.
  logic             in_vld_r;
  rtpst_pkg::hdr_t  in_pay_r;

  // Result register stage.
  logic               out_vld_r;
  rtpst_pkg::result_t out_pay_r;
  rtpst_pkg::result_t out_pay_nxt;

  // Tracking state.
  logic                          tracking_valid_r;
  logic [rtpst_pkg::SrcW-1:0]    current_source_r;
  logic [rtpst_pkg::SeqW-1:0]    expected_seq_r;
  logic [rtpst_pkg::SeqW-1:0]    expected_seq_nxt;
  logic [rtpst_pkg::TimeW-1:0]   expected_time_r;
  logic [rtpst_pkg::TimeW-1:0]   expected_time_nxt;
  logic [rtpst_pkg::TotalW-1:0]  packet_count_r;
  logic [rtpst_pkg::TotalW-1:0]  packet_count_nxt;
  logic [rtpst_pkg::TotalW-1:0]  duplicate_count_r;
  logic [rtpst_pkg::TotalW-1:0]  duplicate_count_nxt;
  logic [rtpst_pkg::TotalW-1:0]  lost_count_r;
  logic [rtpst_pkg::TotalW-1:0]  lost_count_nxt;

  // Check stage working values.
  logic                          advance;
  logic                          in_fire;
  logic                          restart;
  logic [rtpst_pkg::SeqW-1:0]    base_seq;
  logic [rtpst_pkg::TimeW-1:0]   base_time;
  logic [rtpst_pkg::TotalW-1:0]  base_pkt;
  logic [rtpst_pkg::TotalW-1:0]  base_dup;
  logic [rtpst_pkg::TotalW-1:0]  base_lost;
  logic [rtpst_pkg::SeqW-1:0]    seq_delta;
  logic [rtpst_pkg::TimeW-1:0]   time_delta;
  logic                          is_dup;

  // The check stage moves a header into the result register whenever that
  // register is empty or being drained in this cycle.
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.payload = out_pay_r;

  always_comb begin
    // A new source, or no tracking yet, starts from this header: counters
    // start from zero and the expectations equal the header's own values.
    restart   = !tracking_valid_r || (in_pay_r.source_id != current_source_r);
    base_seq  = restart ? in_pay_r.seq_number : expected_seq_r;
    base_time = restart ? in_pay_r.media_time : expected_time_r;
    base_pkt  = restart ? '0 : packet_count_r;
    base_dup  = restart ? '0 : duplicate_count_r;
    base_lost = restart ? '0 : lost_count_r;

    seq_delta  = in_pay_r.seq_number - base_seq;
    time_delta = in_pay_r.media_time - base_time;
    // The half-way step counts as backward.
    is_dup    = seq_delta[rtpst_pkg::SeqW-1];

    packet_count_nxt    = base_pkt + 1'b1;
    duplicate_count_nxt = base_dup;
    lost_count_nxt      = base_lost;
    expected_seq_nxt    = base_seq;
    expected_time_nxt   = base_time;
    out_pay_nxt.verdict   = rtpst_pkg::VERDICT_ACCEPT;
    out_pay_nxt.time_jump = '1;

    if (is_dup) begin
      duplicate_count_nxt = base_dup + 1'b1;
      out_pay_nxt.verdict = rtpst_pkg::VERDICT_DUPLICATE;
    end else begin
      lost_count_nxt = base_lost
                     + {{(rtpst_pkg::TotalW - rtpst_pkg::SeqW){1'b0}}, seq_delta};
      expected_seq_nxt = in_pay_r.seq_number + 1'b1;
      out_pay_nxt.time_jump = $signed(time_delta);
      if (time_delta[rtpst_pkg::TimeW-1]) begin
        // Old timestamp: the sequence has moved on, the time has not.
        out_pay_nxt.verdict = rtpst_pkg::VERDICT_OLD_TIME;
      end else begin
        expected_time_nxt = in_pay_r.media_time
          + {{(rtpst_pkg::TimeW - rtpst_pkg::CntW){1'b0}}, in_pay_r.sample_count};
      end
    end

    out_pay_nxt.packet_total    = packet_count_nxt;
    out_pay_nxt.duplicate_total = duplicate_count_nxt;
    out_pay_nxt.lost_total      = lost_count_nxt;
  end

  // Control and tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r          <= 1'b0;
      out_vld_r         <= 1'b0;
      tracking_valid_r  <= 1'b0;
      current_source_r  <= '0;
      expected_seq_r    <= '0;
      expected_time_r   <= '0;
      packet_count_r    <= '0;
      duplicate_count_r <= '0;
      lost_count_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r         <= 1'b1;
        tracking_valid_r  <= 1'b1;
        current_source_r  <= in_pay_r.source_id;
        expected_seq_r    <= expected_seq_nxt;
        expected_time_r   <= expected_time_nxt;
        packet_count_r    <= packet_count_nxt;
        duplicate_count_r <= duplicate_count_nxt;
        lost_count_r      <= lost_count_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_pay_r <= in_ch.payload;
    end
    if (advance) begin
      out_pay_r <= out_pay_nxt;
    end
  end

  // A held header is never lost while the result side is stalled.
  a_hold_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_pay_r))
    else $error("held header was lost or changed");

  // Any processed header leaves tracking active for its source.
  a_tracking_set: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> tracking_valid_r && current_source_r == $past(in_pay_r.source_id))
    else $error("tracking not established after a header");

  // Without a restart the packet counter steps by exactly one.
  a_pkt_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !restart |=> packet_count_r == $past(packet_count_r) + 1'b1)
    else $error("packet counter did not step by one");

  // A duplicate leaves both expectations untouched.
  a_dup_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_dup |=> $stable(expected_seq_r) && $stable(expected_time_r))
    else $error("duplicate changed the expected sequence or time");

  // A restart can never be judged a duplicate.
  a_restart_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
    advance && restart |-> !is_dup)
    else $error("restart header flagged as duplicate");

endmodule
